### src/dtmf_pkg.sv
// shared constants, types and helper functions for the dual trimmed mean filter
package dtmf_pkg;

	localparam int SAMPLE_W         = 16;
	localparam int DEF_WINDOW_SIZE  = 10;
	localparam int DEF_TRIM         = 2;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_SUM,
		ST_DIV,
		ST_LOAD
	} dtmf_state_t;

	typedef struct packed {
		logic insert;
		logic sum_step;
		logic div_start;
		logic div_step;
		logic load_out;
	} dtmf_cmd_t;

	typedef struct packed {
		logic win_last;
		logic sum_done;
	} dtmf_sts_t;

	function automatic int trim_eff(int w, int t);
		if (2 * t >= w) begin
			return (w - 1) / 2;
		end
		return t;
	endfunction

	function automatic int kept_cnt(int w, int t);
		return w - 2 * trim_eff(w, t);
	endfunction

	function automatic int sum_width(int w, int t);
		return SAMPLE_W + $clog2(kept_cnt(w, t));
	endfunction

endpackage

### src/dtmf_lane.sv
// one channel: insertion-sort cell chain, trimmed accumulator and reciprocal divider
module dtmf_lane #(
	parameter int WINDOW_SIZE = dtmf_pkg::DEF_WINDOW_SIZE,
	parameter int TRIM        = dtmf_pkg::DEF_TRIM
) (
	input  logic                          clk,
	input  dtmf_pkg::dtmf_cmd_t           cmd,
	input  logic [$clog2(WINDOW_SIZE)-1:0] fill,
	input  logic                          add_en,
	input  logic [dtmf_pkg::SAMPLE_W-1:0] sample,
	output logic [dtmf_pkg::SAMPLE_W-1:0] mean
);

	localparam int CNT_W   = $clog2(WINDOW_SIZE);
	localparam int KEPT    = dtmf_pkg::kept_cnt(WINDOW_SIZE, TRIM);
	localparam int SUM_W   = dtmf_pkg::sum_width(WINDOW_SIZE, TRIM);
	localparam int RECIP_S = SUM_W + $clog2(KEPT);
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_M =
		RECIP_W'(((64'd1 << RECIP_S) + 64'(KEPT - 1)) / 64'(KEPT));

	logic [dtmf_pkg::SAMPLE_W-1:0] cells_q [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0]        lt;
	logic [SUM_W-1:0]              acc_q;
	logic [SUM_W-1:0]              acc_nxt;
	logic [SUM_W-1:0]              num_q;
	logic [PROD_W-1:0]             prod;
	logic [dtmf_pkg::SAMPLE_W-1:0] quo_q;
	logic [dtmf_pkg::SAMPLE_W-1:0] mean_q;

	always_comb begin
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			lt[i] = (CNT_W'(i) < fill) && (cells_q[i] <= sample);
		end
	end

	for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
		logic [dtmf_pkg::SAMPLE_W-1:0] ins_val;
		logic [dtmf_pkg::SAMPLE_W-1:0] shf_val;

		if (g == 0) begin : g_first
			assign ins_val = lt[g] ? cells_q[g] : sample;
		end else begin : g_rest
			assign ins_val = lt[g] ? cells_q[g] : (lt[g-1] ? sample : cells_q[g-1]);
		end

		if (g == WINDOW_SIZE - 1) begin : g_top
			assign shf_val = '0;
		end else begin : g_mid
			assign shf_val = cells_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert) begin
				cells_q[g] <= ins_val;
			end else if (cmd.sum_step) begin
				cells_q[g] <= shf_val;
			end
		end
	end

	assign acc_nxt = acc_q + (add_en ? SUM_W'(cells_q[0]) : '0);

	// exact quotient from a rounded-up reciprocal of the kept count
	assign prod = PROD_W'(num_q) * PROD_W'(RECIP_M);

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			acc_q <= '0;
		end else if (cmd.sum_step) begin
			acc_q <= acc_nxt;
		end

		if (cmd.div_start) begin
			num_q <= acc_nxt;
		end

		if (cmd.div_step) begin
			quo_q <= prod[RECIP_S +: dtmf_pkg::SAMPLE_W];
		end

		if (cmd.load_out) begin
			mean_q <= quo_q;
		end
	end

	assign mean = mean_q;

endmodule

### src/dtmf_datapath.sv
// datapath: shared counters and the two channel lanes
module dtmf_datapath #(
	parameter int WINDOW_SIZE = dtmf_pkg::DEF_WINDOW_SIZE,
	parameter int TRIM        = dtmf_pkg::DEF_TRIM
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dtmf_pkg::dtmf_cmd_t           cmd,
	output dtmf_pkg::dtmf_sts_t           sts,
	input  logic [dtmf_pkg::SAMPLE_W-1:0] rp_sample,
	input  logic [dtmf_pkg::SAMPLE_W-1:0] rn_sample,
	output logic [dtmf_pkg::SAMPLE_W-1:0] rp_filtered,
	output logic [dtmf_pkg::SAMPLE_W-1:0] rn_filtered
);

	localparam int CNT_W = $clog2(WINDOW_SIZE);
	localparam int TE    = dtmf_pkg::trim_eff(WINDOW_SIZE, TRIM);

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] k_q;
	logic             add_en;

	assign sts.win_last = fill_q == CNT_W'(WINDOW_SIZE - 1);
	assign sts.sum_done = k_q == CNT_W'(WINDOW_SIZE - TE - 1);
	assign add_en       = k_q >= CNT_W'(TE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			k_q    <= '0;
		end else begin
			if (cmd.insert) begin
				fill_q <= sts.win_last ? '0 : fill_q + CNT_W'(1);
				k_q    <= '0;
			end else if (cmd.sum_step) begin
				k_q <= k_q + CNT_W'(1);
			end
		end
	end

	dtmf_lane #(
		.WINDOW_SIZE(WINDOW_SIZE),
		.TRIM       (TRIM)
	) u_lane_p (
		.clk   (clk),
		.cmd   (cmd),
		.fill  (fill_q),
		.add_en(add_en),
		.sample(rp_sample),
		.mean  (rp_filtered)
	);

	dtmf_lane #(
		.WINDOW_SIZE(WINDOW_SIZE),
		.TRIM       (TRIM)
	) u_lane_n (
		.clk   (clk),
		.cmd   (cmd),
		.fill  (fill_q),
		.add_en(add_en),
		.sample(rn_sample),
		.mean  (rn_filtered)
	);

endmodule

### src/dtmf_ctrl.sv
// controller state machine for window fill, summing, division and result hand-off
module dtmf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  dtmf_pkg::dtmf_sts_t sts,
	output dtmf_pkg::dtmf_cmd_t cmd
);

	dtmf_pkg::dtmf_state_t state_q;
	dtmf_pkg::dtmf_state_t state_nxt;
	logic                  out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dtmf_pkg::ST_FILL: begin
				if (s_tvalid && sts.win_last) begin
					state_nxt = dtmf_pkg::ST_SUM;
				end
			end
			dtmf_pkg::ST_SUM: begin
				if (sts.sum_done) begin
					state_nxt = dtmf_pkg::ST_DIV;
				end
			end
			dtmf_pkg::ST_DIV: begin
				state_nxt = dtmf_pkg::ST_LOAD;
			end
			dtmf_pkg::ST_LOAD: begin
				if (!out_valid_q || m_tready) begin
					state_nxt = dtmf_pkg::ST_FILL;
				end
			end
			default: state_nxt = dtmf_pkg::ST_FILL;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			dtmf_pkg::ST_FILL: begin
				s_tready   = 1'b1;
				cmd.insert = s_tvalid;
			end
			dtmf_pkg::ST_SUM: begin
				cmd.sum_step  = 1'b1;
				cmd.div_start = sts.sum_done;
			end
			dtmf_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			dtmf_pkg::ST_LOAD: begin
				cmd.load_out = !out_valid_q || m_tready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dtmf_pkg::ST_FILL;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

### src/dual_trimmed_mean_filter.sv
// top level of the dual trimmed mean filter
//
//  channel  dir  transaction                     payload
//  s_*      in   one rp/rn sample pair           s_tdata: rp_sample, rn_sample
//  m_*      out  one pair of window means        m_tdata: rp_filtered, rn_filtered
//
// a pair that does not close a window is inserted into the insertion cell chain
// the pair that closes a window is inserted, then the kept samples are summed, then the
// sum is multiplied by the reciprocal and the means are loaded into the output register
// s_tready is low from the closing pair until its means sit in the output register
// the output register holds a result until m_tready; the next window fills meanwhile
// reset clears the fill count, the controller and m_tvalid
module dual_trimmed_mean_filter #(
	parameter int WINDOW_SIZE = dtmf_pkg::DEF_WINDOW_SIZE,
	parameter int TRIM        = dtmf_pkg::DEF_TRIM
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // rp_sample [15:0], rn_sample [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // rp_filtered [15:0], rn_filtered [31:16]
);

	dtmf_pkg::dtmf_cmd_t           cmd;
	dtmf_pkg::dtmf_sts_t           sts;
	logic [dtmf_pkg::SAMPLE_W-1:0] rp_filtered;
	logic [dtmf_pkg::SAMPLE_W-1:0] rn_filtered;

	dtmf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	dtmf_datapath #(
		.WINDOW_SIZE(WINDOW_SIZE),
		.TRIM       (TRIM)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.rp_sample  (s_tdata[15:0]),
		.rn_sample  (s_tdata[31:16]),
		.rp_filtered(rp_filtered),
		.rn_filtered(rn_filtered)
	);

	assign m_tdata = {rn_filtered, rp_filtered};

endmodule
